@@ src/doci_hamiltonian_element_core_defines.svh @@
// assertion macros used by the checker file
`ifndef DOCI_HAMILTONIAN_ELEMENT_CORE_DEFINES_SVH
`define DOCI_HAMILTONIAN_ELEMENT_CORE_DEFINES_SVH

// implication checked only while out of reset
`define DHE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked also across reset
`define DHE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/dhe_pkg.sv @@
// shared types, codes and saturating arithmetic for the matrix element core
package dhe_pkg;

  localparam int VALUE_BITS = 48;
  localparam int ORB_IDX_W  = 5;
  localparam int OCC_W      = 32;
  localparam int KIND_W     = 3;

  localparam logic signed [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // input kind codes
  localparam logic [KIND_W-1:0] KIND_LOAD_ONEBODY = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_ONSITE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LOAD_COULOMB = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LOAD_EXCHANGE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LOAD_PAIRHOP = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DIAGONAL     = 3'd5;
  localparam logic [KIND_W-1:0] KIND_OFFDIAGONAL  = 3'd6;

  // classified operation carried through the queue
  typedef enum logic [2:0] {
    OP_LOAD_T,
    OP_LOAD_V,
    OP_LOAD_C,
    OP_LOAD_E,
    OP_LOAD_P,
    OP_DIAG,
    OP_OFF
  } op_t;

  typedef struct packed {
    op_t                           op;
    logic [ORB_IDX_W-1:0]          hi;
    logic [ORB_IDX_W-1:0]          lo;
    logic signed [VALUE_BITS-1:0]  value;
    logic [OCC_W-1:0]              bits;
    logic                          pair2;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OUTER,
    ST_INNER,
    ST_TERM,
    ST_ADD_A,
    ST_ADD_B,
    ST_OFF_ADDR,
    ST_OFF_DATA
  } back_state_t;

  typedef struct packed {
    logic                         ovf;
    logic signed [VALUE_BITS-1:0] v;
  } sat_t;

  localparam int QDEPTH = 2;

  // saturating add of two in-range values
  function automatic sat_t sat_add(input logic signed [VALUE_BITS-1:0] a,
                                   input logic signed [VALUE_BITS-1:0] b);
    logic signed [VALUE_BITS:0] s;
    sat_t r;
    s = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
    r.ovf = s[VALUE_BITS] ^ s[VALUE_BITS-1];
    r.v = r.ovf ? (s[VALUE_BITS] ? VMIN : VMAX) : s[VALUE_BITS-1:0];
    return r;
  endfunction

  // saturating times two
  function automatic sat_t sat_x2(input logic signed [VALUE_BITS-1:0] x);
    sat_t r;
    r.ovf = x[VALUE_BITS-1] ^ x[VALUE_BITS-2];
    r.v = r.ovf ? (x[VALUE_BITS-1] ? VMIN : VMAX) : {x[VALUE_BITS-2:0], 1'b0};
    return r;
  endfunction

  // saturating times four, same result as doubling twice
  function automatic sat_t sat_x4(input logic signed [VALUE_BITS-1:0] x);
    sat_t r;
    r.ovf = (x[VALUE_BITS-1] != x[VALUE_BITS-2]) || (x[VALUE_BITS-1] != x[VALUE_BITS-3]);
    r.v = r.ovf ? (x[VALUE_BITS-1] ? VMIN : VMAX) : {x[VALUE_BITS-3:0], 2'b00};
    return r;
  endfunction

  // saturating negation
  function automatic sat_t sat_neg(input logic signed [VALUE_BITS-1:0] x);
    sat_t r;
    r.ovf = (x == VMIN);
    r.v = r.ovf ? VMAX : -x;
    return r;
  endfunction

  // index of the single set bit of a one-hot word
  function automatic logic [ORB_IDX_W-1:0] onehot_index(input logic [OCC_W-1:0] oh);
    logic [ORB_IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < OCC_W; i++) begin
      if (oh[i]) idx = idx | ORB_IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

@@ src/dhe_queue.sv @@
// two-entry item queue between front and back
module dhe_queue
  import dhe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  q_entry_t  push_data,
  input  logic      pop,
  output q_entry_t  pop_data,
  output q_status_t status
);

  localparam int PW = $clog2(QDEPTH);

  q_entry_t          mem_r [QDEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]       count_r, count_nxt;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = PW'(wr_ptr_r + 1'b1);
    if (pop) rd_ptr_nxt = PW'(rd_ptr_r + 1'b1);
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  assign pop_data     = mem_r[rd_ptr_r];
  assign status.full  = (count_r == (PW+1)'(QDEPTH));
  assign status.empty = (count_r == '0);

endmodule

@@ src/dhe_front.sv @@
// front end: accepts items, drops ignored ones, classifies the rest
module dhe_front
  import dhe_pkg::*;
#(
  parameter int ORBITALS = 32
) (
  input  logic                         start,
  output logic                         busy,
  input  logic [KIND_W-1:0]            in_kind,
  input  logic [ORB_IDX_W-1:0]         in_orbital_high,
  input  logic [ORB_IDX_W-1:0]         in_orbital_low,
  input  logic signed [VALUE_BITS-1:0] in_table_value,
  input  logic [OCC_W-1:0]             in_bra_bits,
  input  logic [OCC_W-1:0]             in_ket_bits,
  input  q_status_t                    status,
  output logic                         push,
  output q_entry_t                     push_data
);

  localparam logic [OCC_W-1:0] OCC_MASK = (ORBITALS >= OCC_W) ? {OCC_W{1'b1}} :
                                          OCC_W'((64'd1 << ORBITALS) - 64'd1);

  logic             accept;
  logic             hi_ok, lo_ok;
  logic             keep;
  logic [OCC_W-1:0] diff;

  assign busy   = status.full;
  assign accept = start && !status.full;
  assign hi_ok  = int'(in_orbital_high) < ORBITALS;
  assign lo_ok  = int'(in_orbital_low) < ORBITALS;
  assign diff   = (in_bra_bits ^ in_ket_bits) & OCC_MASK;

  // classify kind and range
  always_comb begin
    push_data.hi    = in_orbital_high;
    push_data.lo    = in_orbital_low;
    push_data.value = in_table_value;
    push_data.bits  = in_bra_bits & OCC_MASK;
    push_data.pair2 = 1'b0;
    push_data.op    = OP_DIAG;
    keep            = 1'b0;
    case (in_kind)
      KIND_LOAD_ONEBODY: begin
        push_data.op = OP_LOAD_T;
        keep = hi_ok;
      end
      KIND_LOAD_ONSITE: begin
        push_data.op = OP_LOAD_V;
        keep = hi_ok;
      end
      KIND_LOAD_COULOMB: begin
        push_data.op = OP_LOAD_C;
        keep = hi_ok && lo_ok;
      end
      KIND_LOAD_EXCHANGE: begin
        push_data.op = OP_LOAD_E;
        keep = hi_ok && lo_ok;
      end
      KIND_LOAD_PAIRHOP: begin
        push_data.op = OP_LOAD_P;
        keep = hi_ok && lo_ok;
      end
      KIND_DIAGONAL: begin
        push_data.op = OP_DIAG;
        keep = 1'b1;
      end
      KIND_OFFDIAGONAL: begin
        push_data.op    = OP_OFF;
        push_data.bits  = diff;
        push_data.pair2 = ($countones(diff) == 2);
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push = accept && keep;

endmodule

@@ src/dhe_back.sv @@
// back end: table storage and the sequencer that forms matrix elements
module dhe_back
  import dhe_pkg::*;
#(
  parameter int ORBITALS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  q_status_t                    status,
  input  q_entry_t                     pop_data,
  output logic                         pop,
  output logic                         out_valid,
  output logic signed [VALUE_BITS-1:0] out_element,
  output logic                         out_coupled,
  output logic                         out_saturated
);

  localparam int OW  = $clog2(ORBITALS);
  localparam int PAW = $clog2(ORBITALS * ORBITALS);
  localparam int PAIRS = ORBITALS * ORBITALS;

  // integral tables
  logic signed [VALUE_BITS-1:0] t_mem [ORBITALS];
  logic signed [VALUE_BITS-1:0] v_mem [ORBITALS];
  logic signed [VALUE_BITS-1:0] c_mem [PAIRS];
  logic signed [VALUE_BITS-1:0] e_mem [PAIRS];
  logic signed [VALUE_BITS-1:0] p_mem [PAIRS];
  logic signed [VALUE_BITS-1:0] t_q, v_q, c_q, e_q, p_q;

  back_state_t                  state_r, state_nxt;
  logic [OCC_W-1:0]             cur_r, cur_nxt;
  logic [OCC_W-1:0]             rest_r, rest_nxt;
  logic [ORB_IDX_W-1:0]         s_r, s_nxt;
  logic                         pair_r, pair_nxt;
  logic signed [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                         flag_r, flag_nxt;
  logic signed [VALUE_BITS-1:0] term_a_r, term_a_nxt, term_b_r, term_b_nxt;

  logic                         ov_r, ov_nxt;
  logic signed [VALUE_BITS-1:0] oe_r, oe_nxt;
  logic                         oc_r, oc_nxt, os_r, os_nxt;

  logic                         single_rd, pair_rd, hop_rd;
  logic [OW-1:0]                single_addr;
  logic [PAW-1:0]               pair_addr;
  logic                         we_t, we_v, we_c, we_e, we_p;
  logic [OW-1:0]                wr_single;
  logic [PAW-1:0]               wr_pair;

  logic [OCC_W-1:0]             cur_oh, rest_oh, rest_cut, rest_cut_oh;
  sat_t                         x2_t, x4_c, x2_e, neg_e, add_a, add_b;

  // lowest set bit isolation
  assign cur_oh      = cur_r & (~cur_r + 1'b1);
  assign rest_oh     = rest_r & (~rest_r + 1'b1);
  assign rest_cut    = cur_r & ~cur_oh;
  assign rest_cut_oh = rest_cut & (~rest_cut + 1'b1);

  // term shaping and accumulation
  assign x2_t  = sat_x2(t_q);
  assign x4_c  = sat_x4(c_q);
  assign x2_e  = sat_x2(e_q);
  assign neg_e = sat_neg(x2_e.v);
  assign add_a = sat_add(acc_r, term_a_r);
  assign add_b = sat_add(acc_r, term_b_r);

  // load write decode
  assign wr_single = OW'(pop_data.hi);
  assign wr_pair   = PAW'(PAW'(pop_data.hi) * PAW'(ORBITALS) + PAW'(pop_data.lo));

  // sequencer next state
  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    rest_nxt   = rest_r;
    s_nxt      = s_r;
    pair_nxt   = pair_r;
    acc_nxt    = acc_r;
    flag_nxt   = flag_r;
    term_a_nxt = term_a_r;
    term_b_nxt = term_b_r;
    ov_nxt     = 1'b0;
    oe_nxt     = oe_r;
    oc_nxt     = oc_r;
    os_nxt     = os_r;
    pop        = 1'b0;
    we_t = 1'b0; we_v = 1'b0; we_c = 1'b0; we_e = 1'b0; we_p = 1'b0;
    single_rd   = 1'b0;
    pair_rd     = 1'b0;
    hop_rd      = 1'b0;
    single_addr = OW'(onehot_index(cur_oh));
    // pair tables are indexed by (higher, lower) orbital
    pair_addr   = PAW'(PAW'(onehot_index(rest_oh)) * PAW'(ORBITALS) + PAW'(s_r));
    case (state_r)
      ST_IDLE: begin
        if (!status.empty) begin
          pop = 1'b1;
          case (pop_data.op)
            OP_LOAD_T: we_t = 1'b1;
            OP_LOAD_V: we_v = 1'b1;
            OP_LOAD_C: we_c = 1'b1;
            OP_LOAD_E: we_e = 1'b1;
            OP_LOAD_P: we_p = 1'b1;
            OP_DIAG: begin
              cur_nxt   = pop_data.bits;
              acc_nxt   = '0;
              flag_nxt  = 1'b0;
              state_nxt = ST_OUTER;
            end
            OP_OFF: begin
              cur_nxt = pop_data.bits;
              if (pop_data.pair2) begin
                state_nxt = ST_OFF_ADDR;
              end else begin
                ov_nxt = 1'b1;
                oe_nxt = '0;
                oc_nxt = 1'b0;
                os_nxt = 1'b0;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_OUTER: begin
        if (cur_r == '0) begin
          ov_nxt    = 1'b1;
          oe_nxt    = acc_r;
          oc_nxt    = 1'b1;
          os_nxt    = flag_r;
          state_nxt = ST_IDLE;
        end else begin
          single_rd = 1'b1;
          s_nxt     = onehot_index(cur_oh);
          cur_nxt   = rest_cut;
          rest_nxt  = rest_cut;
          pair_nxt  = 1'b0;
          state_nxt = ST_TERM;
        end
      end
      ST_INNER: begin
        if (rest_r == '0) begin
          state_nxt = ST_OUTER;
        end else begin
          pair_rd   = 1'b1;
          rest_nxt  = rest_r & ~rest_oh;
          pair_nxt  = 1'b1;
          state_nxt = ST_TERM;
        end
      end
      ST_TERM: begin
        if (pair_r) begin
          term_a_nxt = x4_c.v;
          term_b_nxt = neg_e.v;
          flag_nxt   = flag_r | x4_c.ovf | x2_e.ovf | neg_e.ovf;
        end else begin
          term_a_nxt = x2_t.v;
          term_b_nxt = v_q;
          flag_nxt   = flag_r | x2_t.ovf;
        end
        state_nxt = ST_ADD_A;
      end
      ST_ADD_A: begin
        acc_nxt   = add_a.v;
        flag_nxt  = flag_r | add_a.ovf;
        state_nxt = ST_ADD_B;
      end
      ST_ADD_B: begin
        acc_nxt   = add_b.v;
        flag_nxt  = flag_r | add_b.ovf;
        state_nxt = ST_INNER;
      end
      ST_OFF_ADDR: begin
        hop_rd    = 1'b1;
        pair_addr = PAW'(PAW'(onehot_index(rest_cut_oh)) * PAW'(ORBITALS) +
                         PAW'(onehot_index(cur_oh)));
        state_nxt = ST_OFF_DATA;
      end
      ST_OFF_DATA: begin
        ov_nxt    = 1'b1;
        oe_nxt    = p_q;
        oc_nxt    = 1'b1;
        os_nxt    = 1'b0;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    rest_r   <= rest_nxt;
    s_r      <= s_nxt;
    pair_r   <= pair_nxt;
    acc_r    <= acc_nxt;
    flag_r   <= flag_nxt;
    term_a_r <= term_a_nxt;
    term_b_r <= term_b_nxt;
    oe_r     <= oe_nxt;
    oc_r     <= oc_nxt;
    os_r     <= os_nxt;
  end

  // single-orbital tables
  always_ff @(posedge clk) begin
    if (we_t) t_mem[wr_single] <= pop_data.value;
    if (we_v) v_mem[wr_single] <= pop_data.value;
    if (single_rd) begin
      t_q <= t_mem[single_addr];
      v_q <= v_mem[single_addr];
    end
  end

  // pair tables
  always_ff @(posedge clk) begin
    if (we_c) c_mem[wr_pair] <= pop_data.value;
    if (we_e) e_mem[wr_pair] <= pop_data.value;
    if (we_p) p_mem[wr_pair] <= pop_data.value;
    if (pair_rd) begin
      c_q <= c_mem[pair_addr];
      e_q <= e_mem[pair_addr];
    end
    if (hop_rd) p_q <= p_mem[pair_addr];
  end

  assign out_valid     = ov_r;
  assign out_element   = oe_r;
  assign out_coupled   = oc_r;
  assign out_saturated = os_r;

endmodule

@@ src/doci_hamiltonian_element_core.sv @@
// top level of the seniority-zero hamiltonian matrix element core
//
//   channel  | ports                                   | handshake
//   ---------+-----------------------------------------+------------------------
//   input    | in_kind, in_orbital_*, in_table_value,  | start high, busy low
//            | in_bra_bits, in_ket_bits                |
//   result   | out_element, out_coupled, out_saturated | out_valid, one cycle
//
// items wait in a two-entry queue; busy is high while the queue is full
// a load is written to its table as it is popped; an off-diagonal query
// gives an uncoupled zero unless exactly two bits differ; a diagonal query
// sums in the single saturating accumulator, adding two terms per table read
// reset is synchronous and active low; table contents hold no reset value
// results cannot be stalled by the receiver
module doci_hamiltonian_element_core
  import dhe_pkg::*;
#(
  parameter int ORBITALS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [KIND_W-1:0]            in_kind,
  input  logic [ORB_IDX_W-1:0]         in_orbital_high,
  input  logic [ORB_IDX_W-1:0]         in_orbital_low,
  input  logic signed [VALUE_BITS-1:0] in_table_value,
  input  logic [OCC_W-1:0]             in_bra_bits,
  input  logic [OCC_W-1:0]             in_ket_bits,
  output logic                         out_valid,
  output logic signed [VALUE_BITS-1:0] out_element,
  output logic                         out_coupled,
  output logic                         out_saturated
);

  q_status_t q_status;
  q_entry_t  push_data, pop_data;
  logic      push, pop;

  // classify and enqueue
  dhe_front #(.ORBITALS(ORBITALS)) u_front (
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_orbital_high (in_orbital_high),
    .in_orbital_low  (in_orbital_low),
    .in_table_value  (in_table_value),
    .in_bra_bits     (in_bra_bits),
    .in_ket_bits     (in_ket_bits),
    .status          (q_status),
    .push            (push),
    .push_data       (push_data)
  );

  dhe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  // execute
  dhe_back #(.ORBITALS(ORBITALS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .status        (q_status),
    .pop_data      (pop_data),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_element   (out_element),
    .out_coupled   (out_coupled),
    .out_saturated (out_saturated)
  );

endmodule

@@ src/dhe_checker.sv @@
// port-level checks for the matrix element core and their binding
`include "doci_hamiltonian_element_core_defines.svh"

module dhe_checker
  import dhe_pkg::*;
(
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic signed [VALUE_BITS-1:0] out_element,
  input logic                         out_coupled,
  input logic                         out_saturated
);

  // no result straight out of reset
  `DHE_ASSERT_NEXT(a_no_result_after_reset, !rst_n, !out_valid, "result right after reset")

  // an uncoupled result is a plain zero
  `DHE_ASSERT_IMP(a_uncoupled_zero, out_valid && !out_coupled, out_element == '0 && !out_saturated, "uncoupled result not zero")

  // a clamp only happens in a diagonal sum, which is always coupled
  `DHE_ASSERT_IMP(a_sat_coupled, out_valid && out_saturated, out_coupled, "saturated without coupling")

endmodule

bind doci_hamiltonian_element_core dhe_checker u_dhe_checker (.*);
